>>> rtl/chm_pkg.sv
package chm_pkg;

   localparam int NODES       = 8192;
   localparam int MAX_BUCKETS = 8192;

   localparam int KEY_W  = 64;
   localparam int VAL_W  = 16;
   localparam int TAG_W  = 32;
   localparam int CNT_W  = 14;
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = NODE_W + 1;
   localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int REM_W  = $clog2(MAX_BUCKETS + 1);

   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODES);
   localparam logic [CNT_W-1:0] NUM_BUCKETS_RST = CNT_W'(5987);

   // remainder unit: bits of the key consumed per cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = KEY_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CLR_N = (NODES > MAX_BUCKETS) ? NODES : MAX_BUCKETS;
   localparam int CLR_W = $clog2(CLR_N);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_RESET  = 2'd3
   } chm_cmd_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_DELETED  = 3'd5,
      ST_RESET    = 3'd6
   } chm_status_type;

   typedef struct packed {
      chm_cmd_type              cmd;
      logic [KEY_W-1:0]         key;
      logic [VAL_W-1:0]         value;
      logic signed [TAG_W-1:0]  tag;
      logic [BKT_W-1:0]         bucket;
   } chm_item_type;

   typedef struct packed {
      logic init_busy;
   } chm_back_stat_type;

endpackage

>>> rtl/chm_front.sv
module chm_front
   import chm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CNT_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [VAL_W-1:0]        req_value,
   input  logic signed [TAG_W-1:0] req_owner_tag,
   output logic                    item_valid,
   output chm_item_type            item,
   input  logic                    item_ready,
   input  chm_back_stat_type       back_stat
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [CNT_W-1:0] num_buckets_ff, num_buckets_in;
   chm_item_type item_ff, item_in;
   logic [REM_W-1:0] rem_ff, rem_in, n_ff, n_in, n_eff, rem_next;
   logic [KEY_W-1:0] sh_ff, sh_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // zero is used as one, anything above the table size as the table size
   always_comb begin
      if (num_buckets_ff == '0) begin
         n_eff = REM_W'(1);
      end else if (32'(num_buckets_ff) > MAX_BUCKETS) begin
         n_eff = REM_W'(MAX_BUCKETS);
      end else begin
         n_eff = REM_W'(num_buckets_ff);
      end
   end

   // restoring remainder, several key bits per cycle
   always_comb begin
      logic [REM_W:0] t;
      logic [REM_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r, sh_ff[KEY_W-1-i]};
         if (t >= {1'b0, n_ff}) begin
            t = t - {1'b0, n_ff};
         end
         r = t[REM_W-1:0];
      end
      rem_next = r;
   end

   assign req_ready  = (state_ff == F_IDLE) && !back_stat.init_busy;
   assign item_valid = (state_ff == F_PUSH);
   assign item       = item_ff;

   always_comb begin
      state_in       = state_ff;
      num_buckets_in = num_buckets_ff;
      item_in        = item_ff;
      rem_in         = rem_ff;
      n_in           = n_ff;
      sh_in          = sh_ff;
      cnt_in         = cnt_ff;
      if (csr_we) begin
         num_buckets_in = csr_wdata;
      end
      case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               item_in.cmd    = chm_cmd_type'(req_command);
               item_in.key    = req_key;
               item_in.value  = req_value;
               item_in.tag    = req_owner_tag;
               item_in.bucket = '0;
               rem_in         = '0;
               n_in           = n_eff;
               sh_in          = req_key;
               cnt_in         = '0;
               state_in = (chm_cmd_type'(req_command) == CMD_RESET) ? F_PUSH : F_DIV;
            end
         end
         F_DIV: begin
            rem_in = rem_next;
            sh_in  = sh_ff << DIV_BITS;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               item_in.bucket = BKT_W'(rem_next);
               state_in       = F_PUSH;
            end
         end
         F_PUSH: begin
            if (item_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= F_IDLE;
         num_buckets_ff <= NUM_BUCKETS_RST;
      end else begin
         state_ff       <= state_in;
         num_buckets_ff <= num_buckets_in;
      end
      item_ff <= item_in;
      rem_ff  <= rem_in;
      n_ff    <= n_in;
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
   end

endmodule

>>> rtl/chm_queue.sv
module chm_queue
   import chm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  chm_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output chm_item_type pop_item
);

   chm_item_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (32'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (32'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/chm_back.sv
module chm_back
   import chm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  chm_item_type      item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [VAL_W-1:0]  rsp_value_out,
   output chm_back_stat_type back_stat
);

   typedef enum logic [7:0] {
      B_CLEAR = 8'b0000_0001,
      B_IDLE  = 8'b0000_0010,
      B_HEAD  = 8'b0000_0100,
      B_WALK  = 8'b0000_1000,
      B_ALLOC = 8'b0001_0000,
      B_DEL1  = 8'b0010_0000,
      B_DEL2  = 8'b0100_0000,
      B_OUT   = 8'b1000_0000
   } back_state_type;

   logic [LINK_W-1:0]        heads_mem [MAX_BUCKETS];
   logic [KEY_W-1:0]         keys_mem  [NODES];
   logic [VAL_W-1:0]         vals_mem  [NODES];
   logic signed [TAG_W-1:0]  tags_mem  [NODES];
   logic [LINK_W-1:0]        links_mem [NODES];

   logic [LINK_W-1:0] heads_rd_ff, links_rd_ff;
   logic [KEY_W-1:0]  keys_rd_ff;
   logic [VAL_W-1:0]  vals_rd_ff;

   back_state_type state_ff, state_in;
   chm_item_type cur_item_ff, cur_item_in;
   logic [NODE_W-1:0] cur_ff, cur_in, hit_node_ff, hit_node_in;
   logic [LINK_W-1:0] prev_ff, prev_in, head_ff, head_in, hit_link_ff, hit_link_in;
   logic [LINK_W-1:0] free_ff, free_in;
   logic [CLR_W-1:0] clr_idx_ff, clr_idx_in;
   logic clr_cmd_ff, clr_cmd_in;
   chm_status_type res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0] res_value_ff, res_value_in, rsp_value_ff, rsp_value_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic heads_we;
   logic [BKT_W-1:0] heads_waddr;
   logic [LINK_W-1:0] heads_wdata;
   logic links_we;
   logic [NODE_W-1:0] links_waddr;
   logic [LINK_W-1:0] links_wdata;
   logic node_we;
   logic [NODE_W-1:0] node_waddr;
   logic [NODE_W-1:0] node_raddr;
   logic [LINK_W-1:0] clr_link;
   logic key_hit;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign back_stat.init_busy = (state_ff == B_CLEAR) && !clr_cmd_ff;
   assign item_ready    = (state_ff == B_IDLE);
   assign clr_link      = LINK_W'(clr_idx_ff) + LINK_W'(1);
   assign key_hit       = (keys_rd_ff == cur_item_ff.key);

   // a miss on insert reads the free head's link in the same cycle
   always_comb begin
      node_raddr = free_ff[NODE_W-1:0];
      if (state_ff == B_HEAD && heads_rd_ff != LINK_NONE) begin
         node_raddr = heads_rd_ff[NODE_W-1:0];
      end else if (state_ff == B_WALK && !key_hit && links_rd_ff != LINK_NONE) begin
         node_raddr = links_rd_ff[NODE_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_item_in   = cur_item_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      hit_node_in   = hit_node_ff;
      hit_link_in   = hit_link_ff;
      free_in       = free_ff;
      clr_idx_in    = clr_idx_ff;
      clr_cmd_in    = clr_cmd_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      heads_we      = 1'b0;
      heads_waddr   = cur_item_ff.bucket;
      heads_wdata   = LINK_NONE;
      links_we      = 1'b0;
      links_waddr   = cur_ff;
      links_wdata   = LINK_NONE;
      node_we       = 1'b0;
      node_waddr    = cur_ff;
      case (state_ff)
         B_CLEAR: begin
            heads_we    = (32'(clr_idx_ff) < MAX_BUCKETS);
            heads_waddr = BKT_W'(clr_idx_ff);
            heads_wdata = LINK_NONE;
            links_we    = (32'(clr_idx_ff) < NODES);
            links_waddr = NODE_W'(clr_idx_ff);
            links_wdata = clr_link;
            free_in     = '0;
            clr_idx_in  = clr_idx_ff + CLR_W'(1);
            if (32'(clr_idx_ff) == CLR_N - 1) begin
               clr_idx_in = '0;
               if (clr_cmd_ff) begin
                  res_status_in = ST_RESET;
                  res_value_in  = '0;
                  state_in      = B_OUT;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_IDLE: begin
            if (item_valid) begin
               cur_item_in = item;
               if (item.cmd == CMD_RESET) begin
                  clr_cmd_in = 1'b1;
                  clr_idx_in = '0;
                  state_in   = B_CLEAR;
               end else begin
                  state_in = B_HEAD;
               end
            end
         end
         B_HEAD: begin
            prev_in = LINK_NONE;
            head_in = heads_rd_ff;
            if (heads_rd_ff != LINK_NONE) begin
               cur_in   = heads_rd_ff[NODE_W-1:0];
               state_in = B_WALK;
            end else if (cur_item_ff.cmd == CMD_INSERT) begin
               res_value_in = '0;
               if (free_ff == LINK_NONE) begin
                  res_status_in = ST_FULL;
                  state_in      = B_OUT;
               end else begin
                  state_in = B_ALLOC;
               end
            end else begin
               res_status_in = ST_NOTFOUND;
               res_value_in  = '0;
               state_in      = B_OUT;
            end
         end
         B_WALK: begin
            if (key_hit) begin
               hit_node_in = cur_ff;
               hit_link_in = links_rd_ff;
               case (cur_item_ff.cmd)
                  CMD_FIND: begin
                     res_status_in = ST_FOUND;
                     res_value_in  = vals_rd_ff;
                     state_in      = B_OUT;
                  end
                  CMD_INSERT: begin
                     node_we       = 1'b1;
                     node_waddr    = cur_ff;
                     res_status_in = ST_UPDATED;
                     res_value_in  = cur_item_ff.value;
                     state_in      = B_OUT;
                  end
                  default: begin
                     state_in = B_DEL1;
                  end
               endcase
            end else begin
               prev_in = {1'b0, cur_ff};
               if (links_rd_ff != LINK_NONE) begin
                  cur_in = links_rd_ff[NODE_W-1:0];
               end else if (cur_item_ff.cmd == CMD_INSERT) begin
                  res_value_in = '0;
                  if (free_ff == LINK_NONE) begin
                     res_status_in = ST_FULL;
                     state_in      = B_OUT;
                  end else begin
                     state_in = B_ALLOC;
                  end
               end else begin
                  res_status_in = ST_NOTFOUND;
                  res_value_in  = '0;
                  state_in      = B_OUT;
               end
            end
         end
         B_ALLOC: begin
            // link read of the free head landed in links_rd_ff
            node_we       = 1'b1;
            node_waddr    = free_ff[NODE_W-1:0];
            links_we      = 1'b1;
            links_waddr   = free_ff[NODE_W-1:0];
            links_wdata   = head_ff;
            heads_we      = 1'b1;
            heads_waddr   = cur_item_ff.bucket;
            heads_wdata   = free_ff;
            free_in       = links_rd_ff;
            res_status_in = ST_INSERTED;
            res_value_in  = '0;
            state_in      = B_OUT;
         end
         B_DEL1: begin
            if (prev_ff == LINK_NONE) begin
               heads_we    = 1'b1;
               heads_waddr = cur_item_ff.bucket;
               heads_wdata = hit_link_ff;
            end else begin
               links_we    = 1'b1;
               links_waddr = prev_ff[NODE_W-1:0];
               links_wdata = hit_link_ff;
            end
            state_in = B_DEL2;
         end
         B_DEL2: begin
            links_we      = 1'b1;
            links_waddr   = hit_node_ff;
            links_wdata   = free_ff;
            free_in       = {1'b0, hit_node_ff};
            res_status_in = ST_DELETED;
            res_value_in  = '0;
            state_in      = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               clr_cmd_in    = 1'b0;
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (heads_we) begin
         heads_mem[heads_waddr] <= heads_wdata;
      end
      heads_rd_ff <= heads_mem[item.bucket];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         keys_mem[node_waddr] <= cur_item_ff.key;
         vals_mem[node_waddr] <= cur_item_ff.value;
         tags_mem[node_waddr] <= cur_item_ff.tag;
      end
      keys_rd_ff <= keys_mem[node_raddr];
      vals_rd_ff <= vals_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (links_we) begin
         links_mem[links_waddr] <= links_wdata;
      end
      links_rd_ff <= links_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_idx_ff   <= '0;
         clr_cmd_ff   <= 1'b0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_cmd_ff   <= clr_cmd_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_item_ff   <= cur_item_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      head_ff       <= head_in;
      hit_node_ff   <= hit_node_in;
      hit_link_ff   <= hit_link_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

endmodule

>>> rtl/chained_hash_map_with_node_pool.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  command, key, value, owner_tag
// rsp       out        rsp_valid / rsp_ready  status, value_out
// csr       in         csr_we                 csr_wdata (bucket count)
//
// the front takes the key remainder four bits a cycle, and skips the division for reset table
// the back reads the bucket head, then walks the chain one node per cycle, plus
// B_ALLOC for insert of a new node, B_DEL1 and B_DEL2 for delete, B_OUT to load the result register
// after reset, and for a reset table request, a pass over all 8192 entries rewrites heads
// and links; req_ready stays low during the pass after reset
// a two-entry queue lets the front divide while the back walks a chain

module chained_hash_map_with_node_pool
   import chm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CNT_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [VAL_W-1:0]        req_value,
   input  logic signed [TAG_W-1:0] req_owner_tag,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [VAL_W-1:0]        rsp_value_out
);

   logic f_valid, f_ready, q_valid, q_ready;
   chm_item_type f_item, q_item;
   chm_back_stat_type back_stat;

   chm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_key       (req_key),
      .req_value     (req_value),
      .req_owner_tag (req_owner_tag),
      .item_valid    (f_valid),
      .item          (f_item),
      .item_ready    (f_ready),
      .back_stat     (back_stat)
   );

   chm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   chm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (q_valid),
      .item_ready    (q_ready),
      .item          (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .back_stat     (back_stat)
   );

endmodule

>>> verif/hash_map_checker.sv
`timescale 1ns / 1ps

module hash_map_checker
   import chm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CNT_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [VAL_W-1:0]        req_value,
   input  logic signed [TAG_W-1:0] req_owner_tag,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [2:0]              rsp_status,
   input  logic [VAL_W-1:0]        rsp_value_out,
   output int                      fail_count,
   output int                      pending_count
);

   typedef struct packed {
      chm_status_type   status;
      logic [VAL_W-1:0] value_out;
   } map_result_type;

   logic [CNT_W-1:0]        bucket_count;
   logic [LINK_W-1:0]       heads [MAX_BUCKETS];
   logic [KEY_W-1:0]        keys  [NODES];
   logic [VAL_W-1:0]        vals  [NODES];
   logic signed [TAG_W-1:0] tags  [NODES];
   logic [LINK_W-1:0]       links [NODES];
   logic [LINK_W-1:0]       free_node;
   map_result_type          expected_results [$];

   assign pending_count = expected_results.size();

   function automatic void clear_map();
      for (int i = 0; i < MAX_BUCKETS; i++) heads[i] = LINK_NONE;
      for (int i = 0; i < NODES; i++) begin
         keys[i] = '0;
         vals[i] = '0;
         tags[i] = '0;
         links[i] = LINK_W'(i + 1);
      end
      free_node = '0;
   endfunction

   function automatic map_result_type apply_request(chm_cmd_type cmd, logic [KEY_W-1:0] key,
                                                    logic [VAL_W-1:0] val,
                                                    logic signed [TAG_W-1:0] tag);
      map_result_type   r;
      logic [KEY_W-1:0] modulus;
      int               b;
      logic [LINK_W-1:0] cur, prev, hit, hit_prev;
      int               steps;
      r.value_out = '0;
      r.status = ST_NOTFOUND;
      if (cmd == CMD_RESET) begin
         clear_map();
         r.status = ST_RESET;
         return r;
      end
      modulus = bucket_count;
      if (modulus == 0) modulus = 1;
      if (modulus > MAX_BUCKETS) modulus = MAX_BUCKETS;
      b = int'(key % modulus);
      cur = heads[b];
      prev = LINK_NONE;
      hit = LINK_NONE;
      hit_prev = LINK_NONE;
      steps = 0;
      while (cur < LINK_NONE && steps < NODES) begin
         if (keys[cur] == key) begin
            hit = cur;
            hit_prev = prev;
            break;
         end
         prev = cur;
         cur = links[cur];
         steps++;
      end
      case (cmd)
         CMD_INSERT: begin
            if (hit < LINK_NONE) begin
               vals[hit] = val;
               tags[hit] = tag;
               r.status = ST_UPDATED;
               r.value_out = val;
            end else if (free_node >= LINK_NONE) begin
               r.status = ST_FULL;
            end else begin
               cur = free_node;
               free_node = links[cur];
               keys[cur] = key;
               vals[cur] = val;
               tags[cur] = tag;
               links[cur] = heads[b];
               heads[b] = cur;
               r.status = ST_INSERTED;
            end
         end
         CMD_FIND: begin
            if (hit < LINK_NONE) begin
               r.status = ST_FOUND;
               r.value_out = vals[hit];
            end
         end
         default: begin
            if (hit < LINK_NONE) begin
               if (hit_prev < LINK_NONE) links[hit_prev] = links[hit];
               else heads[b] = links[hit];
               links[hit] = free_node;
               free_node = hit;
               r.status = ST_DELETED;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      map_result_type want;
      if (reset) begin
         bucket_count <= NUM_BUCKETS_RST;
         clear_map();
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) bucket_count <= csr_wdata;
         if (req_valid && req_ready)
            expected_results.push_back(apply_request(chm_cmd_type'(req_command), req_key,
                                                     req_value, req_owner_tag));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected response status=%0d", rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status != want.status || rsp_value_out != want.value_out) begin
                  if (fail_count < 10)
                     $display("mismatch: expected status=%0d value=%h, got status=%0d value=%h",
                              want.status, want.value_out, rsp_status, rsp_value_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import chm_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CNT_W-1:0]        csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_command = CMD_FIND;
   logic [KEY_W-1:0]        req_key = '0;
   logic [VAL_W-1:0]        req_value = '0;
   logic signed [TAG_W-1:0] req_owner_tag = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [2:0]              rsp_status;
   logic [VAL_W-1:0]        rsp_value_out;
   int                      fail_count;
   int                      pending_count;
   bit                      hold_rsp = 1'b0;
   logic [KEY_W-1:0]        used_keys [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   chained_hash_map_with_node_pool uut (.*);
   hash_map_checker checker_i (.*);

   function automatic int pick_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // rsp side: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 9) < 7);
   end

   // valid stays up after acceptance until the next request or an idle gap
   task automatic send_request(chm_cmd_type cmd, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] val, logic signed [TAG_W-1:0] tag,
                               int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= key;
      req_value <= val;
      req_owner_tag <= tag;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_buckets(logic [CNT_W-1:0] n);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= n;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      pick_key = {$urandom, $urandom};
      if ($urandom_range(0, 1)) pick_key = pick_key % 64;
      used_keys.push_back(pick_key);
      if (used_keys.size() > 200) void'(used_keys.pop_front());
   endfunction

   task automatic random_phase(int count, int reset_odds);
      chm_cmd_type      cmd;
      int               r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < reset_odds) cmd = CMD_RESET;
         else if (r < 45) cmd = CMD_INSERT;
         else if (r < 75) cmd = CMD_FIND;
         else cmd = CMD_DELETE;
         send_request(cmd, pick_key(), 16'($urandom), $urandom,
                      ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      // directed: extremes of every field and each command
      send_request(CMD_FIND, '0, '0, '0, 0);
      send_request(CMD_INSERT, '0, 16'hffff, 32'sh7fffffff, 0);
      send_request(CMD_INSERT, '1, 16'h0000, -32'sd2147483648, 0);
      send_request(CMD_INSERT, 64'd5987, 16'h1234, -1, 0);
      send_request(CMD_FIND, '0, '0, '0, 0);
      send_request(CMD_FIND, '1, '1, '0, 0);
      send_request(CMD_FIND, 64'd5987, '0, '0, 0);
      send_request(CMD_INSERT, '0, 16'h5a5a, 32'sd1, 0);
      send_request(CMD_FIND, '0, '0, '0, 0);
      send_request(CMD_DELETE, 64'd5987, '0, '0, 0);
      send_request(CMD_DELETE, '0, '0, '0, 0);
      send_request(CMD_DELETE, '0, '0, '0, 0);
      send_request(CMD_FIND, '1, '0, '0, 0);
      send_request(CMD_RESET, '0, '0, '0, 0);
      send_request(CMD_FIND, '1, '0, '0, 0);
      // zero bucket count behaves as one: all keys share a chain
      write_buckets('0);
      send_request(CMD_INSERT, 64'd3, 16'd3, 0, 0);
      send_request(CMD_INSERT, 64'd9, 16'd9, 0, 0);
      send_request(CMD_INSERT, 64'd7, 16'd7, 0, 0);
      send_request(CMD_DELETE, 64'd9, '0, '0, 0);
      send_request(CMD_FIND, 64'd3, '0, '0, 0);
      // count above the maximum is clamped; old entries may now miss
      write_buckets('1);
      send_request(CMD_FIND, 64'd7, '0, '0, 0);
      send_request(CMD_INSERT, 64'd7, 16'd70, 0, 0);
      random_phase(300, 2);
      // long receiver hold-off while requests keep coming
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_rsp <= 1'b0;
         end
         random_phase(20, 0);
      join
      write_buckets(14'd1);
      random_phase(250, 1);
      write_buckets(14'd8192);
      random_phase(250, 1);
      write_buckets(14'd13);
      random_phase(330, 3);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
